// ----- design/amk_pkg.sv -----
// Shared types, constants and the Morse code ROM for the ASCII-to-Morse keyer.
// Depends on nothing; imported by amk_seq, amk_mul and ascii_to_morse_keying.
`timescale 1ns / 1ps
`default_nettype none

package amk_pkg;

    localparam int CHAR_W  = 8;
    localparam int UNIT_W  = 4;
    localparam int SAMP_W  = 12;
    localparam int DUR_W   = 16;
    localparam int ELEM_N  = 7;               // most elements in one pattern
    localparam int ELEM_IW = $clog2(ELEM_N);  // element index width
    localparam int ENTRY_W = 11;              // {count[2:0], pattern[7:0]}
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 12;

    localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'd32;
    localparam logic [CHAR_W-1:0] CH_APOSTROPHE = 8'd39;
    localparam logic [CHAR_W-1:0] CH_BACKQUOTE  = 8'd96;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'd122;
    localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'd32;

    localparam logic [CFG_IW-1:0] CFG_UNIT_SAMPLES = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_DASH_UNITS   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_EGAP_UNITS   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_LGAP_UNITS   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_WGAP_UNITS   = 3'd4;

    localparam logic [SAMP_W-1:0] RST_UNIT_SAMPLES = 12'd60;
    localparam logic [UNIT_W-1:0] RST_DASH_UNITS   = 4'd3;
    localparam logic [UNIT_W-1:0] RST_EGAP_UNITS   = 4'd1;
    localparam logic [UNIT_W-1:0] RST_LGAP_UNITS   = 4'd3;
    localparam logic [UNIT_W-1:0] RST_WGAP_UNITS   = 4'd7;
    localparam logic [UNIT_W-1:0] DOT_UNITS        = 4'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LGAP,
        ST_ELEM,
        ST_EGAP,
        ST_WORD
    } state_t;

    // One keying segment before scaling by the unit length.
    typedef struct packed {
        logic              tone;
        logic [UNIT_W-1:0] units;
        logic              last;
    } seg_t;

    typedef struct packed {
        logic [UNIT_W-1:0] dash;
        logic [UNIT_W-1:0] egap;
        logic [UNIT_W-1:0] lgap;
        logic [UNIT_W-1:0] wgap;
    } gap_cfg_t;

    // Pattern: first element in bit count-1, 1 = dash. Count 0 = unmapped.
    function automatic logic [ENTRY_W-1:0] amk_code_rom(input logic [CHAR_W-1:0] addr);
        logic [ENTRY_W-1:0] w;
        case (addr)
            8'd65:   w = {3'd2, 8'b01};
            8'd66:   w = {3'd4, 8'b1000};
            8'd67:   w = {3'd4, 8'b1010};
            8'd68:   w = {3'd3, 8'b100};
            8'd69:   w = {3'd1, 8'b0};
            8'd70:   w = {3'd4, 8'b0010};
            8'd71:   w = {3'd3, 8'b110};
            8'd72:   w = {3'd4, 8'b0000};
            8'd73:   w = {3'd2, 8'b00};
            8'd74:   w = {3'd4, 8'b0111};
            8'd75:   w = {3'd3, 8'b101};
            8'd76:   w = {3'd4, 8'b0100};
            8'd77:   w = {3'd2, 8'b11};
            8'd78:   w = {3'd2, 8'b10};
            8'd79:   w = {3'd3, 8'b111};
            8'd80:   w = {3'd4, 8'b0110};
            8'd81:   w = {3'd4, 8'b1101};
            8'd82:   w = {3'd3, 8'b010};
            8'd83:   w = {3'd3, 8'b000};
            8'd84:   w = {3'd1, 8'b1};
            8'd85:   w = {3'd3, 8'b001};
            8'd86:   w = {3'd4, 8'b0001};
            8'd87:   w = {3'd3, 8'b011};
            8'd88:   w = {3'd4, 8'b1001};
            8'd89:   w = {3'd4, 8'b1011};
            8'd90:   w = {3'd4, 8'b1100};
            8'd48:   w = {3'd5, 8'b11111};
            8'd49:   w = {3'd5, 8'b01111};
            8'd50:   w = {3'd5, 8'b00111};
            8'd51:   w = {3'd5, 8'b00011};
            8'd52:   w = {3'd5, 8'b00001};
            8'd53:   w = {3'd5, 8'b00000};
            8'd54:   w = {3'd5, 8'b10000};
            8'd55:   w = {3'd5, 8'b11000};
            8'd56:   w = {3'd5, 8'b11100};
            8'd57:   w = {3'd5, 8'b11110};
            8'd33:   w = {3'd6, 8'b101011};
            8'd34:   w = {3'd6, 8'b010010};
            8'd36:   w = {3'd7, 8'b0001001};
            8'd38:   w = {3'd5, 8'b01000};
            8'd39:   w = {3'd6, 8'b011110};
            8'd40:   w = {3'd5, 8'b10110};
            8'd41:   w = {3'd6, 8'b101101};
            8'd43:   w = {3'd5, 8'b01010};
            8'd44:   w = {3'd6, 8'b110011};
            8'd45:   w = {3'd6, 8'b100001};
            8'd46:   w = {3'd6, 8'b010101};
            8'd47:   w = {3'd5, 8'b10010};
            8'd58:   w = {3'd6, 8'b111000};
            8'd59:   w = {3'd6, 8'b101010};
            8'd61:   w = {3'd5, 8'b10001};
            8'd63:   w = {3'd6, 8'b001100};
            8'd64:   w = {3'd6, 8'b011010};
            8'd95:   w = {3'd6, 8'b001101};
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- design/amk_seq.sv -----
// Character sequencer: decodes one byte through the code ROM and walks its
// segments (letter gap, elements, element gaps, word gap). Uses amk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amk_seq import amk_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire gap_cfg_t          gap_cfg,
    output logic                   seg_valid,
    input  wire logic              seg_ready,
    output seg_t                   seg
);

    state_t              state_reg, state_next;
    logic [ELEM_N-1:0]   pat_reg, pat_next;
    logic [ELEM_IW-1:0]  rem_reg, rem_next;
    logic                word_reg, word_next;
    logic                prev_space_reg, prev_space_next;

    logic                is_space, is_word;
    logic [CHAR_W-1:0]   addr;
    logic [ENTRY_W-1:0]  entry;
    logic [ELEM_IW-1:0]  n_elem;
    logic                cur_dash;

    always_comb begin
        is_space = (char_code == CH_SPACE);
        is_word  = is_space || (char_code == CH_NEWLINE);
        if (char_code == CH_BACKQUOTE) begin
            addr = CH_APOSTROPHE;
        end else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) begin
            addr = char_code - CASE_OFFSET;
        end else begin
            addr = char_code;
        end
        entry  = amk_code_rom(addr);
        n_elem = entry[ENTRY_W-1:8];
        cur_dash = pat_reg[rem_reg];
    end

    // next state
    always_comb begin
        state_next      = state_reg;
        pat_next        = pat_reg;
        rem_next        = rem_reg;
        word_next       = word_reg;
        prev_space_next = prev_space_reg;
        case (state_reg)
            ST_IDLE: begin
                // unmapped bytes are dropped and leave the state alone
                if (s_tvalid && (is_word || n_elem != '0)) begin
                    pat_next        = entry[ELEM_N-1:0];
                    rem_next        = n_elem - 1'b1;
                    word_next       = is_word;
                    prev_space_next = is_space;
                    if (!prev_space_reg && !is_space) begin
                        state_next = ST_LGAP;
                    end else if (is_word) begin
                        state_next = ST_WORD;
                    end else begin
                        state_next = ST_ELEM;
                    end
                end
            end
            ST_LGAP: begin
                if (seg_ready) state_next = word_reg ? ST_WORD : ST_ELEM;
            end
            ST_WORD: begin
                if (seg_ready) state_next = ST_IDLE;
            end
            ST_ELEM: begin
                if (seg_ready) state_next = (rem_reg == '0) ? ST_IDLE : ST_EGAP;
            end
            ST_EGAP: begin
                if (seg_ready) begin
                    rem_next   = rem_reg - 1'b1;
                    state_next = ST_ELEM;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready  = 1'b0;
        seg_valid = 1'b1;
        seg       = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                seg_valid = 1'b0;
            end
            ST_LGAP: seg.units = gap_cfg.lgap;
            ST_WORD: begin
                seg.units = gap_cfg.wgap;
                seg.last  = 1'b1;
            end
            ST_ELEM: begin
                seg.tone  = 1'b1;
                seg.units = cur_dash ? gap_cfg.dash : DOT_UNITS;
                seg.last  = (rem_reg == '0);
            end
            ST_EGAP: seg.units = gap_cfg.egap;
            default: seg_valid = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            prev_space_reg <= 1'b1;
        end else begin
            state_reg      <= state_next;
            prev_space_reg <= prev_space_next;
        end
        pat_reg  <= pat_next;
        rem_reg  <= rem_next;
        word_reg <= word_next;
    end

endmodule

`default_nettype wire

// ----- design/amk_mul.sv -----
// Bit-serial scaler: units times unit_samples by shift-and-add, one unit bit
// per cycle, last bit held until the output register is free. Uses amk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amk_mul import amk_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [SAMP_W-1:0] unit_samples,
    input  wire logic              seg_valid,
    output logic                   seg_ready,
    input  wire seg_t              seg,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic                   out_tone,
    output logic [DUR_W-1:0]       out_duration,
    output logic                   out_last
);

    localparam int CNT_W = $clog2(UNIT_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DUR_W-1:0]  acc_reg, acc_next;
    logic [DUR_W-1:0]  md_reg, md_next;
    logic [UNIT_W-1:0] mr_reg, mr_next;
    logic              tone_reg, tone_next;
    logic              last_reg, last_next;
    logic              ovalid_reg, ovalid_next;
    logic              otone_reg, otone_next;
    logic [DUR_W-1:0]  odur_reg, odur_next;
    logic              olast_reg, olast_next;

    logic              out_free, final_step, advance;
    logic [DUR_W-1:0]  step_acc;

    always_comb begin
        out_free   = !ovalid_reg || m_tready;
        final_step = (cnt_reg == CNT_W'(UNIT_W - 1));
        advance    = busy_reg && (!final_step || out_free);
        step_acc   = acc_reg + (mr_reg[0] ? md_reg : '0);
        seg_ready  = !busy_reg;

        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        md_next     = md_reg;
        mr_next     = mr_reg;
        tone_next   = tone_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg && !m_tready;
        otone_next  = otone_reg;
        odur_next   = odur_reg;
        olast_next  = olast_reg;

        if (seg_valid && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            md_next   = DUR_W'(unit_samples);
            mr_next   = seg.units;
            tone_next = seg.tone;
            last_next = seg.last;
        end else if (advance) begin
            acc_next = step_acc;
            md_next  = {md_reg[DUR_W-2:0], 1'b0};
            mr_next  = {1'b0, mr_reg[UNIT_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (final_step) begin
                // product complete: hand it to the output register
                busy_next   = 1'b0;
                ovalid_next = 1'b1;
                otone_next  = tone_reg;
                odur_next   = step_acc;
                olast_next  = last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        md_reg    <= md_next;
        mr_reg    <= mr_next;
        tone_reg  <= tone_next;
        last_reg  <= last_next;
        otone_reg <= otone_next;
        odur_reg  <= odur_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid     = ovalid_reg;
    assign out_tone     = otone_reg;
    assign out_duration = odur_reg;
    assign out_last     = olast_reg;

endmodule

`default_nettype wire

// ----- design/ascii_to_morse_keying.sv -----
// ASCII-to-Morse keyer top level: configuration registers, sequencer and
// serial scaler. Uses amk_pkg, amk_seq and amk_mul.
//
// Each accepted byte yields zero to fourteen keying segments on the master
// stream, the final one flagged by m_tlast; an unmapped byte yields none.
// The shift-and-add scaler loads a segment, then steps through each bit of its
// 4-bit unit count, and takes no new segment until it has finished. A new byte
// is taken once the sequencer has handed its last segment to the scaler.
// Configuration writes are always accepted.
`timescale 1ns / 1ps
`default_nettype none

module ascii_to_morse_keying import amk_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] char_code
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,   // [0] tone_on, [16:1] duration_samples, zero pad
    output logic                   m_tlast,   // last
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data
);

    logic [SAMP_W-1:0] unit_samples_reg;
    logic [UNIT_W-1:0] dash_reg, egap_reg, lgap_reg, wgap_reg;
    gap_cfg_t          gap_cfg;

    logic              seg_valid, seg_ready;
    seg_t              seg;
    logic              out_tone, out_last;
    logic [DUR_W-1:0]  out_duration;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_samples_reg <= RST_UNIT_SAMPLES;
            dash_reg         <= RST_DASH_UNITS;
            egap_reg         <= RST_EGAP_UNITS;
            lgap_reg         <= RST_LGAP_UNITS;
            wgap_reg         <= RST_WGAP_UNITS;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_UNIT_SAMPLES: unit_samples_reg <= cfg_data;
                CFG_DASH_UNITS:   dash_reg <= cfg_data[UNIT_W-1:0];
                CFG_EGAP_UNITS:   egap_reg <= cfg_data[UNIT_W-1:0];
                CFG_LGAP_UNITS:   lgap_reg <= cfg_data[UNIT_W-1:0];
                CFG_WGAP_UNITS:   wgap_reg <= cfg_data[UNIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign gap_cfg = '{dash: dash_reg, egap: egap_reg, lgap: lgap_reg, wgap: wgap_reg};

    amk_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .char_code (s_tdata),
        .gap_cfg   (gap_cfg),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg)
    );

    amk_mul u_mul (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .unit_samples (unit_samples_reg),
        .seg_valid    (seg_valid),
        .seg_ready    (seg_ready),
        .seg          (seg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .out_tone     (out_tone),
        .out_duration (out_duration),
        .out_last     (out_last)
    );

    assign m_tdata = {7'b0, out_duration, out_tone};
    assign m_tlast = out_last;

`ifndef NO_ASSERTIONS
    // sequencer only takes a byte when it has nothing left to hand over
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !seg_valid)
        else $error("byte taken while segments pending");

    // a segment offered to the scaler holds until it is taken
    a_seg_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_valid && !seg_ready |=> seg_valid && $stable(seg))
        else $error("segment changed while stalled");

    // a final silence is always the word gap
    a_word_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && !m_tdata[0] |->
            m_tdata[16:1] == DUR_W'(wgap_reg) * DUR_W'(unit_samples_reg))
        else $error("final silence is not a word gap");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for ascii_to_morse_keying: streams text bytes under several
// timing settings and compares each keying segment with its own prediction.
// Depends on amk_pkg and the ascii_to_morse_keying RTL.
module tb_top;
    import amk_pkg::*;

    localparam logic [CFG_IW-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_SPARE_LAST  = 3'd7;
    localparam int MAX_ELEMS     = ELEM_N;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_CYCLES  = 400;

    typedef struct packed {
        logic             tone;
        logic [DUR_W-1:0] dur;
        logic             last;
    } keying_seg_t;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;   // [7:0] char_code
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [23:0]       m_tdata;          // [0] tone_on, [16:1] duration_samples
    logic              m_tlast;          // last
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    // expected keyer state and timing registers
    logic [SAMP_W-1:0] unit_len;
    logic [UNIT_W-1:0] dash_len, egap_len, lgap_len, wgap_len;
    logic              after_space;

    keying_seg_t seg_q[$];
    logic [7:0]  char_q[$];
    int          mismatches  = 0;
    bit          steady      = 1'b0;
    int          hold_cycles = 0;
    string       punct_set   = "!\"$&'()+,-./:;=?@_";

    ascii_to_morse_keying DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic string morse_pattern(input logic [7:0] c);
        case (c)
            "A": return ".-";      "B": return "-...";    "C": return "-.-.";
            "D": return "-..";     "E": return ".";       "F": return "..-.";
            "G": return "--.";     "H": return "....";    "I": return "..";
            "J": return ".---";    "K": return "-.-";     "L": return ".-..";
            "M": return "--";      "N": return "-.";      "O": return "---";
            "P": return ".--.";    "Q": return "--.-";    "R": return ".-.";
            "S": return "...";     "T": return "-";       "U": return "..-";
            "V": return "...-";    "W": return ".--";     "X": return "-..-";
            "Y": return "-.--";    "Z": return "--..";
            "0": return "-----";   "1": return ".----";   "2": return "..---";
            "3": return "...--";   "4": return "....-";   "5": return ".....";
            "6": return "-....";   "7": return "--...";   "8": return "---..";
            "9": return "----.";
            "!": return "-.-.--";  "\"": return ".-..-."; "$": return "...-..-";
            "&": return ".-...";   "'": return ".----.";  "(": return "-.--.";
            ")": return "-.--.-";  "+": return ".-.-.";   ",": return "--..--";
            "-": return "-....-";  ".": return ".-.-.-";  "/": return "-..-.";
            ":": return "---...";  ";": return "-.-.-.";  "=": return "-...-";
            "?": return "..--..";  "@": return ".--.-.";  "_": return "..--.-";
            default: return "";
        endcase
    endfunction

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        if (c == CH_BACKQUOTE)
            return CH_APOSTROPHE;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            return c - CASE_OFFSET;
        return c;
    endfunction

    function automatic void push_seg(input logic tone, input logic [UNIT_W-1:0] units,
                                     input logic last);
        keying_seg_t s;
        s.tone = tone;
        s.dur  = units * unit_len;
        s.last = last;
        seg_q.push_back(s);
    endfunction

    function automatic void predict_char(input logic [7:0] c);
        string pat;
        logic  is_space, is_word;
        int    n;
        is_space = (c == CH_SPACE);
        is_word  = is_space || (c == CH_NEWLINE);
        pat = "";
        if (!is_word) begin
            pat = morse_pattern(fold_char(c));
            if (pat.len() == 0)
                return;   // unmapped: no segments, state untouched
        end
        n = (pat.len() > MAX_ELEMS) ? MAX_ELEMS : pat.len();
        // newline does not count as a space for the letter gap
        if (!after_space && !is_space)
            push_seg(1'b0, lgap_len, 1'b0);
        if (is_word) begin
            push_seg(1'b0, wgap_len, 1'b1);
        end else begin
            for (int i = 0; i < n; i++) begin
                push_seg(1'b1, (pat[i] == "-") ? dash_len : DOT_UNITS, i == n - 1);
                if (i != n - 1)
                    push_seg(1'b0, egap_len, 1'b0);
            end
        end
        after_space = is_space;
    endfunction

    function automatic void apply_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        case (idx)
            CFG_UNIT_SAMPLES: unit_len = val;
            CFG_DASH_UNITS:   dash_len = val[UNIT_W-1:0];
            CFG_EGAP_UNITS:   egap_len = val[UNIT_W-1:0];
            CFG_LGAP_UNITS:   lgap_len = val[UNIT_W-1:0];
            CFG_WGAP_UNITS:   wgap_len = val[UNIT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void check_seg();
        keying_seg_t      want;
        logic             got_tone;
        logic [DUR_W-1:0] got_dur;
        got_tone = m_tdata[0];
        got_dur  = m_tdata[16:1];
        if (seg_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected segment tone_on %0b duration %0d last %0b",
                     $time, got_tone, got_dur, m_tlast);
            return;
        end
        want = seg_q.pop_front();
        if (want.tone !== got_tone) begin
            mismatches++;
            $display("%0t: tone_on expected %0b got %0b", $time, want.tone, got_tone);
        end
        if (want.dur !== got_dur) begin
            mismatches++;
            $display("%0t: duration_samples expected %0d got %0d", $time, want.dur, got_dur);
        end
        if (want.last !== m_tlast) begin
            mismatches++;
            $display("%0t: last expected %0b got %0b", $time, want.last, m_tlast);
        end
    endfunction

    // input transfers feed the predictor, output transfers are checked
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            predict_char(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            check_seg();
    end

    // byte driver: valid only drops after a transfer or while idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (char_q.size() != 0 && (steady || $urandom_range(0, 99) >= 10)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= char_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= 10);
        end
    end

    task automatic send_char(input logic [7:0] c);
        char_q.push_back(c);
        while (char_q.size() > 1)
            @(posedge aclk);
    endtask

    task automatic wait_idle();
        while (char_q.size() != 0 || s_tvalid || seg_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // writes all five registers plus one unused index, junk in unused data bits
    task automatic set_timing(input logic [SAMP_W-1:0] samples, input logic [UNIT_W-1:0] dash,
                              input logic [UNIT_W-1:0] egap, input logic [UNIT_W-1:0] lgap,
                              input logic [UNIT_W-1:0] wgap);
        logic [CFG_IW-1:0] idx [6];
        logic [CFG_DW-1:0] val [6];
        wait_idle();
        idx[0] = CFG_IW'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST));
        val[0] = CFG_DW'($urandom);
        idx[1] = CFG_UNIT_SAMPLES;  val[1] = samples;
        idx[2] = CFG_DASH_UNITS;    val[2] = {8'($urandom), dash};
        idx[3] = CFG_EGAP_UNITS;    val[3] = {8'($urandom), egap};
        idx[4] = CFG_LGAP_UNITS;    val[4] = {8'($urandom), lgap};
        idx[5] = CFG_WGAP_UNITS;    val[5] = {8'($urandom), wgap};
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            apply_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return 8'($urandom_range(65, 90));
        if (r < 45) return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
        if (r < 55) return 8'($urandom_range(48, 57));
        if (r < 67) return punct_set[$urandom_range(0, punct_set.len() - 1)];
        if (r < 77) return CH_SPACE;
        if (r < 82) return CH_NEWLINE;
        if (r < 85) return CH_BACKQUOTE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_text(input int count);
        repeat (count) send_char(random_char());
    endtask

    // reset timing: folding, word gaps, back-to-back newlines, unmapped bytes
    task automatic test_directed_chars();
        logic [7:0] seq[$];
        seq = '{"E", "T", CH_SPACE, "e", CH_BACKQUOTE, "'", "$", "0", CH_NEWLINE,
                CH_NEWLINE, "A", 8'h00, 8'hFF, "#", "Z", CH_SPACE, CH_SPACE, "z",
                "?", "_", "9", "~", "."};
        foreach (seq[i])
            send_char(seq[i]);
        wait_idle();
    endtask

    // output held off long enough to fill the block and stall its input
    task automatic test_output_stall();
        wait_idle();
        hold_cycles = STALL_CYCLES;
        run_text(24);
        wait_idle();
    endtask

    task automatic test_setting_sweep();
        set_timing(12'd4095, 4'd15, 4'd15, 4'd15, 4'd15);
        run_text(30);
        set_timing(12'd1, 4'd1, 4'd1, 4'd1, 4'd1);
        run_text(30);
        set_timing(12'd0, 4'd0, 4'd0, 4'd0, 4'd0);
        run_text(20);
        set_timing(SAMP_W'($urandom_range(1, 4095)), UNIT_W'($urandom_range(1, 15)),
                   UNIT_W'($urandom_range(1, 15)), UNIT_W'($urandom_range(1, 15)),
                   UNIT_W'($urandom_range(1, 15)));
        steady = 1'b1;
        run_text(25);
        wait_idle();
        steady = 1'b0;
        set_timing(SAMP_W'($urandom_range(1, 4095)), UNIT_W'($urandom_range(1, 15)),
                   UNIT_W'($urandom_range(1, 15)), UNIT_W'($urandom_range(1, 15)),
                   UNIT_W'($urandom_range(1, 15)));
        run_text(18);
        wait_idle();
    endtask

    initial begin
        unit_len    = RST_UNIT_SAMPLES;
        dash_len    = RST_DASH_UNITS;
        egap_len    = RST_EGAP_UNITS;
        lgap_len    = RST_LGAP_UNITS;
        wgap_len    = RST_WGAP_UNITS;
        after_space = 1'b1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_chars();
        test_output_stall();
        test_setting_sweep();
        wait_idle();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
